// ===== design/dna_base_and_bigram_counter_unit_assert.svh =====
// Assertion macros for the DNA base and bigram counter unit.
`ifndef DNA_BASE_AND_BIGRAM_COUNTER_UNIT_ASSERT_SVH
`define DNA_BASE_AND_BIGRAM_COUNTER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define DBCU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dbcu assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define DBCU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dbcu assertion failed");

`endif

// ===== design/dbcu_pkg.sv =====
// Package: types, constants and helpers for the DNA base and bigram counter unit.
package dbcu_pkg;

    // Counter widths
    localparam int SEQ_COUNT_BITS   = 16;
    localparam int TOTAL_COUNT_BITS = 32;

    // Field widths
    localparam int COMMAND_W     = 2;
    localparam int SYMBOL_W      = 8;
    localparam int INDEX_W       = 5;
    localparam int COUNT_VALUE_W = 32;

    // Counter map
    localparam int NUM_SEQ           = 20;
    localparam int NUM_COMMITTED     = 22;
    localparam int BIGRAM_BASE       = 4;
    localparam int IDX_TOTAL_CHARS   = 20;
    localparam int IDX_TOTAL_BIGRAMS = 21;

    // Character codes (lower case); OR-ing in the case bit folds A-Z only for letters
    localparam logic [SYMBOL_W-1:0] CHAR_A   = 8'h61;
    localparam logic [SYMBOL_W-1:0] CHAR_C   = 8'h63;
    localparam logic [SYMBOL_W-1:0] CHAR_T   = 8'h74;
    localparam logic [SYMBOL_W-1:0] CHAR_G   = 8'h67;
    localparam logic [SYMBOL_W-1:0] CASE_BIT = 8'h20;

    typedef logic [SEQ_COUNT_BITS-1:0]   seq_cnt_t;
    typedef logic [TOTAL_COUNT_BITS-1:0] tot_cnt_t;

    localparam seq_cnt_t SEQ_MAX = '1;

    typedef enum logic [COMMAND_W-1:0] {
        CMD_SYMBOL = 2'd0,
        CMD_END    = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_READ   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        BASE_A = 2'd0,
        BASE_C = 2'd1,
        BASE_T = 2'd2,
        BASE_G = 2'd3
    } base_t;

    typedef struct packed {
        logic  ok;
        base_t code;
    } base_dec_t;

    // Per-sequence control into the tracker
    typedef struct packed {
        logic                symbol_go;
        logic                end_go;
        logic [SYMBOL_W-1:0] symbol;
    } seq_ctl_t;

    // Per-sequence status out of the tracker
    typedef struct packed {
        seq_cnt_t [NUM_SEQ-1:0] counts;
        seq_cnt_t               length;
        logic                   bad;
    } seq_status_t;

    // Control into the committed counter bank
    typedef struct packed {
        logic               clear;
        logic               commit;
        logic [INDEX_W-1:0] index;
    } bank_ctl_t;

    // Fold case and map a byte to a base code
    function automatic base_dec_t decode_base(input logic [SYMBOL_W-1:0] sym);
        logic [SYMBOL_W-1:0] low;
        base_dec_t           d;
        low    = sym | CASE_BIT;
        d.ok   = 1'b1;
        d.code = BASE_A;
        if (low == CHAR_A)
        begin
            d.code = BASE_A;
        end
        else if (low == CHAR_C)
        begin
            d.code = BASE_C;
        end
        else if (low == CHAR_T)
        begin
            d.code = BASE_T;
        end
        else if (low == CHAR_G)
        begin
            d.code = BASE_G;
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

// ===== design/dbcu_if.sv =====
// Valid/ready channel interfaces for command and result transactions.
interface dbcu_in_if;
    import dbcu_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [COMMAND_W-1:0] command;
    logic [SYMBOL_W-1:0]  symbol;
    logic                 do_count;
    logic [INDEX_W-1:0]   counter_index;

    modport source (output valid, output command, output symbol, output do_count,
                    output counter_index, input ready);
    modport sink   (input valid, input command, input symbol, input do_count,
                    input counter_index, output ready);
endinterface

interface dbcu_out_if;
    import dbcu_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     seq_valid;
    logic [COUNT_VALUE_W-1:0] count_value;

    modport source (output valid, output seq_valid, output count_value, input ready);
    modport sink   (input valid, input seq_valid, input count_value, output ready);
endinterface

// ===== design/dna_base_and_bigram_counter_unit.sv =====
// Top level of the DNA base and bigram counter unit.
// Result path: an accepted command is registered in the input stage, and its result then loads the result register.
// Throughput: one command transaction per cycle; only a result-bearing command waits on a
// full, unread output register.
// Reset: rst_n (async, active low) zeroes all committed and per-sequence counters.
`include "dna_base_and_bigram_counter_unit_assert.svh"

module dna_base_and_bigram_counter_unit (
    input logic       clk,
    input logic       rst_n,
    dbcu_in_if.sink   item,
    dbcu_out_if.source result
);
    import dbcu_pkg::*;

    // Input stage
    logic                 s1_valid_reg;
    cmd_t                 s1_cmd_reg;
    logic [SYMBOL_W-1:0]  s1_symbol_reg;
    logic                 s1_do_count_reg;
    logic [INDEX_W-1:0]   s1_index_reg;

    // Result stage
    logic                     out_valid_reg;
    logic                     out_seq_valid_reg;
    logic [COUNT_VALUE_W-1:0] out_count_reg;

    logic                     s1_has_result;
    logic                     s1_go;
    logic                     item_take;
    logic                     seq_ok;
    logic                     seq_full;
    seq_ctl_t                 seq_ctl;
    seq_status_t              seq_status;
    bank_ctl_t                bank_ctl;
    logic [COUNT_VALUE_W-1:0] rd_data;

    // Stage handshake: non-result commands never wait on the output
    assign s1_has_result = (s1_cmd_reg == CMD_END) || (s1_cmd_reg == CMD_READ);
    assign s1_go         = s1_valid_reg &&
                           (!s1_has_result || !out_valid_reg || result.ready);
    assign item.ready    = !s1_valid_reg || s1_go;
    assign item_take     = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_cmd_reg      <= cmd_t'(item.command);
            s1_symbol_reg   <= item.symbol;
            s1_do_count_reg <= item.do_count;
            s1_index_reg    <= item.counter_index;
        end
    end

    // Control for the tracker and the counter bank
    assign seq_ok   = (seq_status.length != '0) && !seq_status.bad;
    assign seq_full = (seq_status.length == SEQ_MAX);

    assign seq_ctl.symbol_go = s1_go && (s1_cmd_reg == CMD_SYMBOL);
    assign seq_ctl.end_go    = s1_go && (s1_cmd_reg == CMD_END);
    assign seq_ctl.symbol    = s1_symbol_reg;

    assign bank_ctl.clear  = s1_go && (s1_cmd_reg == CMD_CLEAR);
    assign bank_ctl.commit = s1_go && (s1_cmd_reg == CMD_END) && seq_ok && s1_do_count_reg;
    assign bank_ctl.index  = s1_index_reg;

    dbcu_seq_tracker u_seq_tracker (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (seq_ctl),
        .status (seq_status)
    );

    dbcu_commit_bank u_commit_bank (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (bank_ctl),
        .status  (seq_status),
        .rd_data (rd_data)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_go && s1_has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_has_result)
        begin
            if (s1_cmd_reg == CMD_END)
            begin
                out_seq_valid_reg <= seq_ok;
                out_count_reg     <= '0;
            end
            else
            begin
                out_seq_valid_reg <= 1'b0;
                out_count_reg     <= rd_data;
            end
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.seq_valid   = out_seq_valid_reg;
    assign result.count_value = out_count_reg;

    // Checks
    `DBCU_ASSERT_NEXT(a_stall_holds, s1_valid_reg && !s1_go, s1_valid_reg && $stable(s1_cmd_reg))
    `DBCU_ASSERT_NEXT(a_end_clears_seq, seq_ctl.end_go, seq_status.length == '0 && !seq_status.bad)
    `DBCU_ASSERT_NEXT(a_overlong_bad, seq_ctl.symbol_go && seq_full, seq_status.bad && seq_full)
    `DBCU_ASSERT_NOW(a_result_source, $rose(out_valid_reg), $past(s1_go && s1_has_result))
endmodule

// ===== design/dbcu_seq_tracker.sv =====
// Per-sequence tentative base and bigram counters, length and bad flag.
module dbcu_seq_tracker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  dbcu_pkg::seq_ctl_t    ctl,
    output dbcu_pkg::seq_status_t status
);
    import dbcu_pkg::*;

    seq_cnt_t [NUM_SEQ-1:0] counts_reg;
    seq_cnt_t [NUM_SEQ-1:0] counts_next;
    seq_cnt_t               length_reg;
    seq_cnt_t               length_next;
    logic                   bad_reg;
    logic                   bad_next;
    base_t                  prev_reg;
    base_t                  prev_next;
    logic                   have_prev_reg;
    logic                   have_prev_next;

    base_dec_t          dec;
    logic               room;
    logic               count_base;
    logic [INDEX_W-1:0] bigram_idx;

    assign dec        = decode_base(ctl.symbol);
    assign room       = (length_reg != SEQ_MAX);
    assign count_base = ctl.symbol_go && room && dec.ok;
    assign bigram_idx = INDEX_W'(BIGRAM_BASE) + INDEX_W'({prev_reg, dec.code});

    // Next state for one symbol or end of sequence
    always_comb
    begin
        counts_next    = counts_reg;
        length_next    = length_reg;
        bad_next       = bad_reg;
        prev_next      = prev_reg;
        have_prev_next = have_prev_reg;
        if (ctl.end_go)
        begin
            counts_next    = '0;
            length_next    = '0;
            bad_next       = 1'b0;
            prev_next      = BASE_A;
            have_prev_next = 1'b0;
        end
        else if (ctl.symbol_go)
        begin
            if (!room)
            begin
                bad_next = 1'b1;
            end
            else
            begin
                length_next = length_reg + seq_cnt_t'(1);
                if (!dec.ok)
                begin
                    bad_next = 1'b1;
                end
            end
            if (count_base)
            begin
                prev_next      = dec.code;
                have_prev_next = 1'b1;
            end
            for (int i = 0; i < NUM_SEQ; i++)
            begin
                if (count_base && ((INDEX_W'(i) == INDEX_W'(dec.code)) ||
                                   (have_prev_reg && INDEX_W'(i) == bigram_idx)))
                begin
                    counts_next[i] = counts_reg[i] + seq_cnt_t'(1);
                end
            end
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counts_reg    <= '0;
            length_reg    <= '0;
            bad_reg       <= 1'b0;
            prev_reg      <= BASE_A;
            have_prev_reg <= 1'b0;
        end
        else
        begin
            counts_reg    <= counts_next;
            length_reg    <= length_next;
            bad_reg       <= bad_next;
            prev_reg      <= prev_next;
            have_prev_reg <= have_prev_next;
        end
    end

    assign status.counts = counts_reg;
    assign status.length = length_reg;
    assign status.bad    = bad_reg;
endmodule

// ===== design/dbcu_commit_bank.sv =====
// Committed counters: clear, commit of a finished sequence, and indexed read.
module dbcu_commit_bank (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dbcu_pkg::bank_ctl_t       ctl,
    input  dbcu_pkg::seq_status_t     status,
    output logic [dbcu_pkg::COUNT_VALUE_W-1:0] rd_data
);
    import dbcu_pkg::*;

    tot_cnt_t [NUM_COMMITTED-1:0] cnt_reg;
    tot_cnt_t [NUM_COMMITTED-1:0] cnt_next;
    tot_cnt_t                     rd_full;

    // Add the tentative counts and totals in parallel; wrap at counter width
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctl.clear)
        begin
            cnt_next = '0;
        end
        else if (ctl.commit)
        begin
            for (int i = 0; i < NUM_SEQ; i++)
            begin
                cnt_next[i] = cnt_reg[i] + tot_cnt_t'(status.counts[i]);
            end
            cnt_next[IDX_TOTAL_CHARS]   = cnt_reg[IDX_TOTAL_CHARS] +
                                          tot_cnt_t'(status.length);
            cnt_next[IDX_TOTAL_BIGRAMS] = cnt_reg[IDX_TOTAL_BIGRAMS] +
                                          tot_cnt_t'(status.length - seq_cnt_t'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Read select; indexes past the last counter read zero
    always_comb
    begin
        rd_full = '0;
        for (int i = 0; i < NUM_COMMITTED; i++)
        begin
            if (ctl.index == INDEX_W'(i))
            begin
                rd_full = cnt_reg[i];
            end
        end
    end

    assign rd_data = COUNT_VALUE_W'(rd_full);
endmodule

// ===== bench/tb.sv =====
// Testbench for the DNA base and bigram counter unit: directed table, long runs, random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dbcu_pkg::*;

    typedef struct packed {
        logic                     seq_valid;
        logic [COUNT_VALUE_W-1:0] count_value;
    } report_t;

    // One directed row; typed rows carry their own expected result
    typedef struct packed {
        cmd_t                     cmd;
        logic [SYMBOL_W-1:0]      sym;
        logic                     do_count;
        logic [INDEX_W-1:0]       idx;
        bit                       typed;
        logic                     want_valid;
        logic [COUNT_VALUE_W-1:0] want_value;
    } row_t;

    localparam int NUM_ROWS = 27;
    localparam int RANDOM_PER_PHASE = 444;
    localparam int LONG_RUN_A = 48;
    localparam int LONG_RUN_B = 24;

    localparam row_t DIRECTED_ROWS [NUM_ROWS] = '{
        '{CMD_READ,   8'h00, 1'b0, 5'd0,  1'b1, 1'b0, 32'd0},  // counters are zero after reset
        '{CMD_READ,   8'h00, 1'b0, 5'd21, 1'b1, 1'b0, 32'd0},
        '{CMD_READ,   8'hFF, 1'b1, 5'd31, 1'b1, 1'b0, 32'd0},  // index past the map
        '{CMD_END,    8'h00, 1'b1, 5'd0,  1'b1, 1'b0, 32'd0},  // empty sequence
        '{CMD_SYMBOL, 8'h41, 1'b0, 5'd0,  1'b0, 1'b0, 32'd0},  // 'A'
        '{CMD_SYMBOL, 8'h63, 1'b0, 5'd0,  1'b0, 1'b0, 32'd0},  // 'c'
        '{CMD_SYMBOL, 8'h54, 1'b0, 5'd0,  1'b0, 1'b0, 32'd0},  // 'T'
        '{CMD_SYMBOL, 8'h67, 1'b0, 5'd0,  1'b0, 1'b0, 32'd0},  // 'g'
        '{CMD_SYMBOL, 8'h61, 1'b0, 5'd0,  1'b0, 1'b0, 32'd0},  // 'a'
        '{CMD_END,    8'h00, 1'b1, 5'd0,  1'b1, 1'b1, 32'd0},  // valid, committed
        '{CMD_READ,   8'h00, 1'b0, 5'd0,  1'b0, 1'b0, 32'd0},
        '{CMD_READ,   8'h00, 1'b0, 5'd5,  1'b0, 1'b0, 32'd0},
        '{CMD_READ,   8'h00, 1'b0, 5'd16, 1'b0, 1'b0, 32'd0},
        '{CMD_READ,   8'h00, 1'b0, 5'd20, 1'b0, 1'b0, 32'd0},
        '{CMD_READ,   8'h00, 1'b0, 5'd21, 1'b0, 1'b0, 32'd0},
        '{CMD_SYMBOL, 8'h47, 1'b0, 5'd0,  1'b0, 1'b0, 32'd0},  // 'G'
        '{CMD_END,    8'h00, 1'b0, 5'd0,  1'b1, 1'b1, 32'd0},  // valid, not committed
        '{CMD_SYMBOL, 8'h00, 1'b0, 5'd0,  1'b0, 1'b0, 32'd0},  // non-base byte
        '{CMD_SYMBOL, 8'h41, 1'b0, 5'd0,  1'b0, 1'b0, 32'd0},
        '{CMD_END,    8'h00, 1'b1, 5'd0,  1'b1, 1'b0, 32'd0},  // bad sequence
        '{CMD_SYMBOL, 8'h43, 1'b0, 5'd0,  1'b0, 1'b0, 32'd0},  // 'C'
        '{CMD_CLEAR,  8'h00, 1'b0, 5'd0,  1'b0, 1'b0, 32'd0},  // clear mid-sequence
        '{CMD_SYMBOL, 8'h63, 1'b0, 5'd0,  1'b0, 1'b0, 32'd0},  // 'c'
        '{CMD_END,    8'h00, 1'b1, 5'd0,  1'b1, 1'b1, 32'd0},
        '{CMD_READ,   8'h00, 1'b0, 5'd9,  1'b0, 1'b0, 32'd0},  // CC survives the clear
        '{CMD_SYMBOL, 8'hFF, 1'b0, 5'd0,  1'b0, 1'b0, 32'd0},
        '{CMD_END,    8'h00, 1'b1, 5'd0,  1'b1, 1'b0, 32'd0}
    };

    logic clk;
    logic rst_n;

    dbcu_in_if  item_ch ();
    dbcu_out_if res_ch ();

    dna_base_and_bigram_counter_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch)
    );

    // Predicted block state
    tot_cnt_t committed [NUM_COMMITTED];
    seq_cnt_t seq_cnt [NUM_SEQ];
    seq_cnt_t seq_len;
    base_t    prev_base;
    logic     have_prev;
    logic     seq_bad;

    report_t pending_reports [$];
    int      mismatches;
    int      send_idle_pct;
    int      recv_stall_pct;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Receiver: random stalls, changed at the falling edge
    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch: %s got %0h want %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic void restart_sequence();
        for (int i = 0; i < NUM_SEQ; i++)
        begin
            seq_cnt[i] = '0;
        end
        seq_len   = '0;
        prev_base = BASE_A;
        have_prev = 1'b0;
        seq_bad   = 1'b0;
    endfunction

    // Advance predicted state by one command; returns 1 when it yields a result
    function automatic bit apply_command(input cmd_t c, input logic [SYMBOL_W-1:0] s,
                                         input logic dc, input logic [INDEX_W-1:0] x,
                                         output report_t r);
        logic [SYMBOL_W-1:0] low;
        base_t               code;
        logic                is_base;
        logic                ok;
        r = '0;
        case (c)
            CMD_SYMBOL:
            begin
                if (seq_len == SEQ_MAX)
                begin
                    seq_bad = 1'b1;
                end
                else
                begin
                    seq_len++;
                    low = (s >= 8'h41 && s <= 8'h5A) ? s + 8'h20 : s;
                    is_base = 1'b1;
                    code = BASE_A;
                    if (low == CHAR_A)
                        code = BASE_A;
                    else if (low == CHAR_C)
                        code = BASE_C;
                    else if (low == CHAR_T)
                        code = BASE_T;
                    else if (low == CHAR_G)
                        code = BASE_G;
                    else
                        is_base = 1'b0;
                    if (!is_base)
                    begin
                        seq_bad = 1'b1;
                    end
                    else
                    begin
                        seq_cnt[int'(code)]++;
                        if (have_prev)
                            seq_cnt[BIGRAM_BASE + 4 * int'(prev_base) + int'(code)]++;
                        prev_base = code;
                        have_prev = 1'b1;
                    end
                end
                return 1'b0;
            end
            CMD_END:
            begin
                ok = (seq_len != 0) && !seq_bad;
                if (ok && dc)
                begin
                    for (int i = 0; i < NUM_SEQ; i++)
                    begin
                        committed[i] = committed[i] + tot_cnt_t'(seq_cnt[i]);
                    end
                    committed[IDX_TOTAL_CHARS]   = committed[IDX_TOTAL_CHARS] + tot_cnt_t'(seq_len);
                    committed[IDX_TOTAL_BIGRAMS] = committed[IDX_TOTAL_BIGRAMS]
                                                   + tot_cnt_t'(seq_len) - 1;
                end
                restart_sequence();
                r.seq_valid = ok;
                return 1'b1;
            end
            CMD_CLEAR:
            begin
                for (int i = 0; i < NUM_COMMITTED; i++)
                begin
                    committed[i] = '0;
                end
                return 1'b0;
            end
            default:
            begin
                r.count_value = (x < NUM_COMMITTED) ? committed[x] : '0;
                return 1'b1;
            end
        endcase
    endfunction

    // Drive one command transaction at the falling edge, wait for acceptance, predict
    task automatic put_item(input cmd_t c, input logic [SYMBOL_W-1:0] s, input logic dc,
                            input logic [INDEX_W-1:0] x, input bit typed, input report_t want);
        report_t got;
        bit      has_result;
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid         <= 1'b1;
        item_ch.command       <= c;
        item_ch.symbol        <= s;
        item_ch.do_count      <= dc;
        item_ch.counter_index <= x;
        do
        begin
            @(posedge clk);
        end
        while (!item_ch.ready);
        has_result = apply_command(c, s, dc, x, got);
        if (has_result)
            pending_reports.push_back(typed ? want : got);
        @(negedge clk);
    endtask

    function automatic logic [SYMBOL_W-1:0] random_base_char();
        logic [SYMBOL_W-1:0] ch;
        case ($urandom_range(3))
            0: ch = CHAR_A;
            1: ch = CHAR_C;
            2: ch = CHAR_T;
            default: ch = CHAR_G;
        endcase
        if ($urandom_range(1))
            ch = ch & ~CASE_BIT;
        return ch;
    endfunction

    // Mostly short well-formed sequences, with noise bytes, clears and reads mixed in
    task automatic run_random(input int n);
        int                  pick;
        cmd_t                c;
        logic [SYMBOL_W-1:0] s;
        logic                dc;
        logic [INDEX_W-1:0]  x;
        for (int k = 0; k < n; k++)
        begin
            pick = $urandom_range(99);
            s    = SYMBOL_W'($urandom_range(255));
            dc   = 1'($urandom_range(1));
            x    = INDEX_W'($urandom_range(31));
            if (pick < 58)
            begin
                c = CMD_SYMBOL;
                if ($urandom_range(19) != 0)
                    s = random_base_char();
            end
            else if (pick < 70)
            begin
                c = CMD_END;
                dc = ($urandom_range(3) != 0);
            end
            else if (pick < 72)
            begin
                c = CMD_CLEAR;
            end
            else
            begin
                c = CMD_READ;
                if ($urandom_range(9) != 0)
                    x = INDEX_W'($urandom_range(NUM_COMMITTED - 1));
            end
            put_item(c, s, dc, x, 1'b0, '0);
        end
    endtask

    task automatic run_long(input int len);
        for (int k = 0; k < len; k++)
        begin
            put_item(CMD_SYMBOL, random_base_char(), 1'b0, 5'd0, 1'b0, '0);
        end
        put_item(CMD_END, 8'h00, 1'b1, 5'd0, 1'b0, '0);
    endtask

    // Hold the sender off until every expected result is back
    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    // Result checker, sampled at the rising edge
    always @(posedge clk)
    begin
        report_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                flag_mismatch("unexpected result transaction", res_ch.count_value, '0);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (res_ch.seq_valid !== want.seq_valid)
                    flag_mismatch("seq_valid", 32'(res_ch.seq_valid), 32'(want.seq_valid));
                if (res_ch.count_value !== want.count_value)
                    flag_mismatch("count_value", res_ch.count_value, want.count_value);
            end
        end
    end

    initial
    begin
        int      idle_by_phase  [4];
        int      stall_by_phase [4];
        report_t typed_want;
        idle_by_phase  = '{0, 75, 0, 21};
        stall_by_phase = '{0, 0, 75, 21};

        item_ch.valid         = 1'b0;
        item_ch.command       = CMD_SYMBOL;
        item_ch.symbol        = '0;
        item_ch.do_count      = 1'b0;
        item_ch.counter_index = '0;
        rst_n                 = 1'b0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;
        mismatches            = 0;
        for (int i = 0; i < NUM_COMMITTED; i++)
        begin
            committed[i] = '0;
        end
        restart_sequence();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            typed_want.seq_valid   = DIRECTED_ROWS[r].want_valid;
            typed_want.count_value = DIRECTED_ROWS[r].want_value;
            put_item(DIRECTED_ROWS[r].cmd, DIRECTED_ROWS[r].sym, DIRECTED_ROWS[r].do_count,
                     DIRECTED_ROWS[r].idx, DIRECTED_ROWS[r].typed, typed_want);
        end

        // Long well-formed sequences, with every counter read back in between
        run_long(LONG_RUN_A);
        for (int i = 0; i < NUM_COMMITTED; i++)
        begin
            put_item(CMD_READ, 8'h00, 1'b0, INDEX_W'(i), 1'b0, '0);
        end
        run_long(LONG_RUN_B);
        put_item(CMD_READ, 8'h00, 1'b0, 5'(IDX_TOTAL_CHARS), 1'b0, '0);
        wait_drained();

        // Random traffic under each idling pattern
        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct  = idle_by_phase[p];
            recv_stall_pct = stall_by_phase[p];
            run_random(RANDOM_PER_PHASE);
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+design
design/dbcu_pkg.sv
design/dbcu_if.sv
design/dbcu_seq_tracker.sv
design/dbcu_commit_bank.sv
design/dna_base_and_bigram_counter_unit.sv
bench/tb.sv
